// ===== design/rcsam_pkg.sv =====
// shared types and constants for the rc stick arming and command mapper
package rcsam_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GESTURE_LO    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GESTURE_HI    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ARM_HOLD_TIME = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNLOCK_RETRY  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEADZONE_RP   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DEADZONE_YAW  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SW_LO         = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SW_HI         = 3'd7;

    // register reset values
    localparam logic [11:0] RST_GESTURE_LO    = 12'd1150;
    localparam logic [11:0] RST_GESTURE_HI    = 12'd1850;
    localparam logic [15:0] RST_ARM_HOLD_TIME = 16'd500;
    localparam logic [15:0] RST_UNLOCK_RETRY  = 16'd100;
    localparam logic [8:0]  RST_DEADZONE_RP   = 9'd40;
    localparam logic [8:0]  RST_DEADZONE_YAW  = 9'd80;
    localparam logic [11:0] RST_SW_LO         = 12'd1200;
    localparam logic [11:0] RST_SW_HI         = 12'd1700;

    // stick mapping constants
    localparam int MID_VALUE        = 1500;
    localparam int LOW_VALUE        = 1000;
    localparam int THR_SPAN         = 1000;
    localparam int ANGLE_FULL_SCALE = 3500;
    localparam int MAX_YAW          = 200;
    localparam int ANGLE_DIV        = 460;
    localparam int YAW_DIV          = 420;
    localparam int FAILSAFE_THR     = 350;

    // scaling by reciprocal: q = (mag * MUL) >> SHIFT, exact for clamped magnitudes
    localparam int ANGLE_NUM   = ANGLE_FULL_SCALE / 20;
    localparam int ANGLE_DEN   = ANGLE_DIV / 20;
    localparam int ANGLE_SHIFT = 24;
    localparam int ANGLE_RECIP = ((1 << ANGLE_SHIFT) + ANGLE_DEN - 1) / ANGLE_DEN;
    localparam int ANGLE_MUL   = ANGLE_NUM * ANGLE_RECIP;
    localparam int ANGLE_MUL_BITS = 27;

    localparam int YAW_NUM   = MAX_YAW / 20;
    localparam int YAW_DEN   = YAW_DIV / 20;
    localparam int YAW_SHIFT = 16;
    localparam int YAW_RECIP = ((1 << YAW_SHIFT) + YAW_DEN - 1) / YAW_DEN;
    localparam int YAW_MUL   = YAW_NUM * YAW_RECIP;
    localparam int YAW_MUL_BITS = 15;

    localparam int MAG_BITS   = 9;
    localparam int ANGLE_BITS = 12;
    localparam int YAW_BITS   = 8;

    // switch position codes
    localparam logic [1:0] POS_LOW  = 2'd0;
    localparam logic [1:0] POS_MID  = 2'd1;
    localparam logic [1:0] POS_HIGH = 2'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH      = 2;
    localparam int QUEUE_PTR_BITS   = 1;
    localparam int QUEUE_COUNT_BITS = 2;

    typedef struct packed {
        logic [11:0] gesture_lo;
        logic [11:0] gesture_hi;
        logic [15:0] arm_hold_time;
        logic [15:0] unlock_retry_period;
        logic [8:0]  deadzone_roll_pitch;
        logic [8:0]  deadzone_yaw;
        logic [11:0] sw_lo_limit;
        logic [11:0] sw_hi_limit;
    } cfg_t;

    typedef struct packed {
        logic                neg;
        logic [MAG_BITS-1:0] mag;
    } mag_t;

    // one classified item
    typedef struct packed {
        logic        lost;
        logic        disarm_gesture;
        logic        arm_gesture;
        logic [7:0]  tick;
        mag_t        roll;
        mag_t        pitch;
        mag_t        yaw;
        logic [9:0]  thr_cmd;
        logic [11:0] switch_pos;
        logic [1:0]  mode_pos;
        logic [1:0]  knob_a_pos;
    } frame_t;

endpackage

// ===== design/rcsam_front.sv =====
// front end: accepts items and classifies sticks, switches and gestures
module rcsam_front
    import rcsam_pkg::*;
#(
    parameter int CHANNEL_BITS = 12
)
(
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [CHANNEL_BITS-1:0] roll_channel,
    input  logic [CHANNEL_BITS-1:0] pitch_channel,
    input  logic [CHANNEL_BITS-1:0] throttle_channel,
    input  logic [CHANNEL_BITS-1:0] yaw_channel,
    input  logic [CHANNEL_BITS-1:0] aux1_channel,
    input  logic [CHANNEL_BITS-1:0] aux2_channel,
    input  logic [CHANNEL_BITS-1:0] aux3_channel,
    input  logic [CHANNEL_BITS-1:0] aux4_channel,
    input  logic [CHANNEL_BITS-1:0] aux5_channel,
    input  logic [CHANNEL_BITS-1:0] aux6_channel,
    input  logic                    link_lost,
    input  logic [7:0]              tick_ms,
    input  cfg_t                    cfg,
    input  logic                    queue_full,
    output logic                    push,
    output frame_t                  frame
);

    localparam int CMPW = (CHANNEL_BITS > 12) ? CHANNEL_BITS : 12;
    localparam int VW   = CHANNEL_BITS + 2;

    function automatic logic below(input logic [CHANNEL_BITS-1:0] ch,
                                   input logic [11:0] lim);
        return CMPW'(ch) < CMPW'(lim);
    endfunction

    function automatic logic above(input logic [CHANNEL_BITS-1:0] ch,
                                   input logic [11:0] lim);
        return CMPW'(ch) > CMPW'(lim);
    endfunction

    function automatic logic [1:0] position(input logic [CHANNEL_BITS-1:0] ch,
                                            input logic [11:0] lo,
                                            input logic [11:0] hi);
        logic [1:0] p;
        if (below(ch, lo))
            p = POS_LOW;
        else if (below(ch, hi))
            p = POS_MID;
        else
            p = POS_HIGH;
        return p;
    endfunction

    // offset from centre, deadzone, then clamp to the full-scale magnitude
    function automatic mag_t deadband(input logic [CHANNEL_BITS-1:0] ch,
                                      input logic [8:0] dz,
                                      input logic [8:0] lim);
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] dzs;
        logic [VW-1:0]        m;
        mag_t                 r;
        v   = $signed({2'b00, ch}) - $signed(VW'(MID_VALUE));
        dzs = $signed(VW'(dz));
        r.neg = 1'b0;
        if (v > dzs)
        begin
            m = v - dzs;
        end
        else if (v < -dzs)
        begin
            m = -v - dzs;
            r.neg = 1'b1;
        end
        else
        begin
            m = '0;
        end
        if (m > VW'(lim))
            r.mag = lim;
        else
            r.mag = m[MAG_BITS-1:0];
        return r;
    endfunction

    // handshake into the queue
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // classification
    always_comb
    begin
        frame.lost = link_lost;
        frame.tick = (tick_ms == 8'd0) ? 8'd1 : tick_ms;

        frame.disarm_gesture = below(throttle_channel, cfg.gesture_lo)
                            && below(yaw_channel, cfg.gesture_lo)
                            && above(roll_channel, cfg.gesture_hi)
                            && below(pitch_channel, cfg.gesture_lo);
        frame.arm_gesture = below(throttle_channel, cfg.gesture_lo)
                         && above(yaw_channel, cfg.gesture_hi)
                         && below(roll_channel, cfg.gesture_lo)
                         && below(pitch_channel, cfg.gesture_lo);

        frame.roll  = deadband(roll_channel, cfg.deadzone_roll_pitch, 9'(ANGLE_DIV));
        frame.pitch = deadband(pitch_channel, cfg.deadzone_roll_pitch, 9'(ANGLE_DIV));
        frame.yaw   = deadband(yaw_channel, cfg.deadzone_yaw, 9'(YAW_DIV));

        if (throttle_channel < CHANNEL_BITS'(LOW_VALUE))
            frame.thr_cmd = '0;
        else if (throttle_channel > CHANNEL_BITS'(LOW_VALUE + THR_SPAN))
            frame.thr_cmd = 10'(THR_SPAN);
        else
            frame.thr_cmd = 10'(throttle_channel - CHANNEL_BITS'(LOW_VALUE));

        frame.mode_pos   = position(aux1_channel, cfg.sw_lo_limit,
                                    cfg.sw_hi_limit);
        frame.knob_a_pos = position(aux5_channel, cfg.sw_lo_limit,
                                    cfg.sw_hi_limit);
        frame.switch_pos = {
            position(aux4_channel, cfg.sw_lo_limit, cfg.sw_hi_limit),
            frame.knob_a_pos,
            position(aux6_channel, cfg.sw_lo_limit, cfg.sw_hi_limit),
            frame.mode_pos,
            position(aux3_channel, cfg.sw_lo_limit, cfg.sw_hi_limit),
            position(aux2_channel, cfg.sw_lo_limit, cfg.sw_hi_limit)
        };
    end

endmodule

// ===== design/rcsam_queue.sv =====
// two-entry queue of classified items between front and back
module rcsam_queue
    import rcsam_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  frame_t push_frame,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output frame_t head_frame
);

    frame_t                      entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0]   rd_ptr_reg;
    logic [QUEUE_COUNT_BITS-1:0] count_reg;
    logic [QUEUE_COUNT_BITS-1:0] count_next;

    assign full       = (count_reg == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_frame = entry_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_frame;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_COUNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("item pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("item popped from empty queue");

endmodule

// ===== design/rcsam_back.sv =====
// back end: arming state, unlock retry, radar latch and command scaling
module rcsam_back
    import rcsam_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              head_valid,
    input  frame_t            head_frame,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic signed [12:0] roll_cmd,
    output logic signed [12:0] pitch_cmd,
    output logic [9:0]        throttle_cmd,
    output logic signed [8:0] yaw_rate_cmd,
    output logic [1:0]        flight_mode,
    output logic              failsafe_active,
    output logic              motors_armed,
    output logic              unlock_request,
    output logic [11:0]       switch_positions,
    output logic              radar_power
);

    localparam int CMPW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                      input logic [7:0] b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + (COUNT_BITS+1)'(b);
        return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    // state
    logic                  armed_reg, armed_next;
    logic [COUNT_BITS-1:0] hold_reg, hold_next;
    logic [COUNT_BITS-1:0] retry_reg, retry_next;
    logic                  radar_reg, radar_next;
    logic [1:0]            mode_reg, mode_next;
    logic                  out_valid_reg, out_valid_next;

    // output payload
    logic signed [12:0] roll_reg, roll_next;
    logic signed [12:0] pitch_reg, pitch_next;
    logic [9:0]         thr_reg, thr_next;
    logic signed [8:0]  yaw_reg, yaw_next;
    logic               failsafe_reg;
    logic               unlock_reg, unlock_next;
    logic [11:0]        switch_reg;

    logic [CMPW-1:0]       period_ext;
    logic [COUNT_BITS-1:0] period_clip;
    logic [MAG_BITS+ANGLE_MUL_BITS-1:0] roll_prod, pitch_prod;
    logic [MAG_BITS+YAW_MUL_BITS-1:0]   yaw_prod;
    logic [ANGLE_BITS-1:0] roll_q, pitch_q;
    logic [YAW_BITS-1:0]   yaw_q;
    logic                  take;

    // item moves from queue to output register
    assign take = head_valid && (!out_valid_reg || out_ready);
    assign pop  = take;

    assign period_ext  = CMPW'(cfg.unlock_retry_period);
    assign period_clip = (period_ext > CMPW'(COUNT_MAX)) ? COUNT_MAX
                                                         : COUNT_BITS'(period_ext);

    // arm state machine and counters
    always_comb
    begin
        armed_next  = armed_reg;
        hold_next   = hold_reg;
        retry_next  = retry_reg;
        unlock_next = 1'b0;
        if (head_frame.lost || head_frame.disarm_gesture)
        begin
            armed_next = 1'b0;
            hold_next  = '0;
            retry_next = '0;
        end
        else
        begin
            if (!armed_reg && head_frame.arm_gesture)
            begin
                if (CMPW'(hold_reg) < CMPW'(cfg.arm_hold_time))
                begin
                    hold_next = sat_add(hold_reg, head_frame.tick);
                end
                else
                begin
                    armed_next  = 1'b1;
                    retry_next  = period_clip;
                    unlock_next = 1'b1;
                end
            end
            else
            begin
                hold_next = '0;
            end
            if (armed_next)
            begin
                if (CMPW'(retry_next) < period_ext)
                begin
                    retry_next = sat_add(retry_next, head_frame.tick);
                end
                else
                begin
                    retry_next  = '0;
                    unlock_next = 1'b1;
                end
            end
        end
    end

    // radar latch and held flight mode
    always_comb
    begin
        radar_next = radar_reg;
        if (head_frame.knob_a_pos == POS_HIGH)
            radar_next = 1'b1;
        else if (head_frame.knob_a_pos == POS_LOW)
            radar_next = 1'b0;
        mode_next = head_frame.lost ? mode_reg : (head_frame.mode_pos + 2'd1);
    end

    // command scaling by reciprocal multiply
    assign roll_prod  = head_frame.roll.mag * ANGLE_MUL_BITS'(ANGLE_MUL);
    assign pitch_prod = head_frame.pitch.mag * ANGLE_MUL_BITS'(ANGLE_MUL);
    assign yaw_prod   = head_frame.yaw.mag * YAW_MUL_BITS'(YAW_MUL);
    assign roll_q     = roll_prod[ANGLE_SHIFT +: ANGLE_BITS];
    assign pitch_q    = pitch_prod[ANGLE_SHIFT +: ANGLE_BITS];
    assign yaw_q      = yaw_prod[YAW_SHIFT +: YAW_BITS];

    // command select: failsafe, armed or zero
    always_comb
    begin
        roll_next  = '0;
        pitch_next = '0;
        thr_next   = '0;
        yaw_next   = '0;
        if (head_frame.lost)
        begin
            thr_next = 10'(FAILSAFE_THR);
        end
        else if (armed_next)
        begin
            roll_next  = head_frame.roll.neg ? -$signed({1'b0, roll_q})
                                             :  $signed({1'b0, roll_q});
            pitch_next = head_frame.pitch.neg ?  $signed({1'b0, pitch_q})
                                              : -$signed({1'b0, pitch_q});
            yaw_next   = head_frame.yaw.neg ?  $signed({1'b0, yaw_q})
                                            : -$signed({1'b0, yaw_q});
            thr_next   = head_frame.thr_cmd;
        end
    end

    // output handshake
    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            hold_reg      <= '0;
            retry_reg     <= '0;
            radar_reg     <= 1'b0;
            mode_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                armed_reg <= armed_next;
                hold_reg  <= hold_next;
                retry_reg <= retry_next;
                radar_reg <= radar_next;
                mode_reg  <= mode_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            roll_reg     <= roll_next;
            pitch_reg    <= pitch_next;
            thr_reg      <= thr_next;
            yaw_reg      <= yaw_next;
            failsafe_reg <= head_frame.lost;
            unlock_reg   <= unlock_next;
            switch_reg   <= head_frame.switch_pos;
        end
    end

    assign out_valid        = out_valid_reg;
    assign roll_cmd         = roll_reg;
    assign pitch_cmd        = pitch_reg;
    assign throttle_cmd     = thr_reg;
    assign yaw_rate_cmd     = yaw_reg;
    assign flight_mode      = mode_reg;
    assign failsafe_active  = failsafe_reg;
    assign motors_armed     = armed_reg;
    assign unlock_request   = unlock_reg;
    assign switch_positions = switch_reg;
    assign radar_power      = radar_reg;

    // checks
    a_failsafe_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && failsafe_reg |-> !armed_reg && thr_reg == 10'(FAILSAFE_THR))
        else $error("failsafe item not disarmed with failsafe throttle");

    a_unlock_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && unlock_reg |-> armed_reg)
        else $error("unlock sent while disarmed");

    a_disarmed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !armed_reg && !failsafe_reg |->
            roll_reg == '0 && pitch_reg == '0 && thr_reg == '0 && yaw_reg == '0)
        else $error("nonzero command while disarmed");

endmodule

// ===== design/rc_stick_arming_and_command_mapper_core.sv =====
// top level: configuration registers, front end, item queue and back end
// an accepted item is written into the queue, then moved into the output register when that register is free
// throughput: one item per cycle while out_ready is high; the back end updates the arm state once per item
// a two-entry queue lets the input keep accepting while a result waits on out_ready
// reset: configuration returns to defaults, disarmed, counters, radar latch and mode cleared
// reset also empties the queue and drops any pending result
module rc_stick_arming_and_command_mapper_core
    import rcsam_pkg::*;
#(
    parameter int CHANNEL_BITS = 12,
    parameter int COUNT_BITS   = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CHANNEL_BITS-1:0]   roll_channel,
    input  logic [CHANNEL_BITS-1:0]   pitch_channel,
    input  logic [CHANNEL_BITS-1:0]   throttle_channel,
    input  logic [CHANNEL_BITS-1:0]   yaw_channel,
    input  logic [CHANNEL_BITS-1:0]   aux1_channel,
    input  logic [CHANNEL_BITS-1:0]   aux2_channel,
    input  logic [CHANNEL_BITS-1:0]   aux3_channel,
    input  logic [CHANNEL_BITS-1:0]   aux4_channel,
    input  logic [CHANNEL_BITS-1:0]   aux5_channel,
    input  logic [CHANNEL_BITS-1:0]   aux6_channel,
    input  logic                      link_lost,
    input  logic [7:0]                tick_ms,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [12:0]        roll_cmd,
    output logic signed [12:0]        pitch_cmd,
    output logic [9:0]                throttle_cmd,
    output logic signed [8:0]         yaw_rate_cmd,
    output logic [1:0]                flight_mode,
    output logic                      failsafe_active,
    output logic                      motors_armed,
    output logic                      unlock_request,
    output logic [11:0]               switch_positions,
    output logic                      radar_power
);

    cfg_t   cfg_reg;
    logic   queue_full;
    logic   push;
    logic   pop;
    logic   head_valid;
    frame_t push_frame;
    frame_t head_frame;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gesture_lo          <= RST_GESTURE_LO;
            cfg_reg.gesture_hi          <= RST_GESTURE_HI;
            cfg_reg.arm_hold_time       <= RST_ARM_HOLD_TIME;
            cfg_reg.unlock_retry_period <= RST_UNLOCK_RETRY;
            cfg_reg.deadzone_roll_pitch <= RST_DEADZONE_RP;
            cfg_reg.deadzone_yaw        <= RST_DEADZONE_YAW;
            cfg_reg.sw_lo_limit         <= RST_SW_LO;
            cfg_reg.sw_hi_limit         <= RST_SW_HI;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_GESTURE_LO:    cfg_reg.gesture_lo          <= cfg_data[11:0];
                REG_GESTURE_HI:    cfg_reg.gesture_hi          <= cfg_data[11:0];
                REG_ARM_HOLD_TIME: cfg_reg.arm_hold_time       <= cfg_data[15:0];
                REG_UNLOCK_RETRY:  cfg_reg.unlock_retry_period <= cfg_data[15:0];
                REG_DEADZONE_RP:   cfg_reg.deadzone_roll_pitch <= cfg_data[8:0];
                REG_DEADZONE_YAW:  cfg_reg.deadzone_yaw        <= cfg_data[8:0];
                REG_SW_LO:         cfg_reg.sw_lo_limit         <= cfg_data[11:0];
                REG_SW_HI:         cfg_reg.sw_hi_limit         <= cfg_data[11:0];
            endcase
        end
    end

    // classification
    rcsam_front #(
        .CHANNEL_BITS(CHANNEL_BITS)
    ) u_front (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .roll_channel     (roll_channel),
        .pitch_channel    (pitch_channel),
        .throttle_channel (throttle_channel),
        .yaw_channel      (yaw_channel),
        .aux1_channel     (aux1_channel),
        .aux2_channel     (aux2_channel),
        .aux3_channel     (aux3_channel),
        .aux4_channel     (aux4_channel),
        .aux5_channel     (aux5_channel),
        .aux6_channel     (aux6_channel),
        .link_lost        (link_lost),
        .tick_ms          (tick_ms),
        .cfg              (cfg_reg),
        .queue_full       (queue_full),
        .push             (push),
        .frame            (push_frame)
    );

    // item queue
    rcsam_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_frame (head_frame)
    );

    // state update and commands
    rcsam_back #(
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .head_valid       (head_valid),
        .head_frame       (head_frame),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .roll_cmd         (roll_cmd),
        .pitch_cmd        (pitch_cmd),
        .throttle_cmd     (throttle_cmd),
        .yaw_rate_cmd     (yaw_rate_cmd),
        .flight_mode      (flight_mode),
        .failsafe_active  (failsafe_active),
        .motors_armed     (motors_armed),
        .unlock_request   (unlock_request),
        .switch_positions (switch_positions),
        .radar_power      (radar_power)
    );

endmodule

// ===== verif/rc_stick_arming_and_command_mapper_core_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the rc stick arming and command mapper core
module rc_stick_arming_and_command_mapper_core_test
    import rcsam_pkg::*;
();

    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT      = 2000;
    localparam int PHASE_ITEMS      = 270;

    // one rc frame as seen on the input ports
    typedef struct packed {
        logic [11:0] roll;
        logic [11:0] pitch;
        logic [11:0] thr;
        logic [11:0] yaw;
        logic [11:0] aux1;
        logic [11:0] aux2;
        logic [11:0] aux3;
        logic [11:0] aux4;
        logic [11:0] aux5;
        logic [11:0] aux6;
        logic        lost;
        logic [7:0]  tick;
    } rc_frame_t;

    // one command set, field order matches the output concatenation below
    typedef struct packed {
        logic signed [12:0] roll;
        logic signed [12:0] pitch;
        logic [9:0]         thr;
        logic signed [8:0]  yaw;
        logic [1:0]         mode;
        logic               failsafe;
        logic               armed;
        logic               unlock;
        logic [11:0]        switches;
        logic               radar;
    } cmd_set_t;

    // mirrors the arming state machine and stick mapping, keeps expected command sets
    class cmd_scoreboard;
        logic [11:0] gesture_lo, gesture_hi, sw_lo_lim, sw_hi_lim;
        logic [15:0] arm_hold_time, unlock_period;
        logic [8:0]  dz_rp, dz_yaw;
        logic        armed, radar;
        logic [15:0] hold_count, retry_count;
        logic [1:0]  held_mode;
        cmd_set_t    pending_cmds[$];
        int          errors;
        int          results_seen;

        function new();
            gesture_lo    = RST_GESTURE_LO;
            gesture_hi    = RST_GESTURE_HI;
            arm_hold_time = RST_ARM_HOLD_TIME;
            unlock_period = RST_UNLOCK_RETRY;
            dz_rp         = RST_DEADZONE_RP;
            dz_yaw        = RST_DEADZONE_YAW;
            sw_lo_lim     = RST_SW_LO;
            sw_hi_lim     = RST_SW_HI;
            armed         = 1'b0;
            radar         = 1'b0;
            hold_count    = '0;
            retry_count   = '0;
            held_mode     = '0;
            errors        = 0;
            results_seen  = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
            case (idx)
                REG_GESTURE_LO:    gesture_lo    = value[11:0];
                REG_GESTURE_HI:    gesture_hi    = value[11:0];
                REG_ARM_HOLD_TIME: arm_hold_time = value;
                REG_UNLOCK_RETRY:  unlock_period = value;
                REG_DEADZONE_RP:   dz_rp         = value[8:0];
                REG_DEADZONE_YAW:  dz_yaw        = value[8:0];
                REG_SW_LO:         sw_lo_lim     = value[11:0];
                REG_SW_HI:         sw_hi_lim     = value[11:0];
            endcase
        endfunction

        function logic [1:0] position(logic [11:0] ch);
            if (ch < sw_lo_lim)
                return POS_LOW;
            if (ch < sw_hi_lim)
                return POS_MID;
            return POS_HIGH;
        endfunction

        function logic [15:0] sat_count(int v);
            return (v > 65535) ? 16'hFFFF : v[15:0];
        endfunction

        function int apply_deadzone(int v, int dz);
            if (v > dz)
                return v - dz;
            if (v < -dz)
                return v + dz;
            return 0;
        endfunction

        function int saturate(int v, int lo, int hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        // advance the state by one frame and work out its command set
        function cmd_set_t predict_commands(rc_frame_t f);
            cmd_set_t c;
            int dt, dr, dp, dy, r, p, y, t;
            logic arm_gesture, disarm_gesture;
            logic [1:0] knob_a;
            c = '0;
            r = 0;
            p = 0;
            y = 0;
            t = 0;
            dt = (f.tick == 8'd0) ? 1 : int'(f.tick);

            // switch decode and radar latch run even on signal loss
            c.switches = {position(f.aux4), position(f.aux5), position(f.aux6),
                          position(f.aux1), position(f.aux3), position(f.aux2)};
            knob_a = position(f.aux5);
            if (knob_a == POS_HIGH)
                radar = 1'b1;
            else if (knob_a == POS_LOW)
                radar = 1'b0;

            // arm and disarm
            disarm_gesture = f.thr < gesture_lo && f.yaw < gesture_lo &&
                             f.roll > gesture_hi && f.pitch < gesture_lo;
            if (f.lost || disarm_gesture)
            begin
                armed       = 1'b0;
                hold_count  = '0;
                retry_count = '0;
            end
            else
            begin
                arm_gesture = f.thr < gesture_lo && f.yaw > gesture_hi &&
                              f.roll < gesture_lo && f.pitch < gesture_lo;
                if (!armed && arm_gesture)
                begin
                    if (hold_count < arm_hold_time)
                        hold_count = sat_count(int'(hold_count) + dt);
                    else
                    begin
                        armed       = 1'b1;
                        retry_count = unlock_period;
                        c.unlock    = 1'b1;
                    end
                end
                else
                    hold_count = '0;
                if (armed)
                begin
                    if (retry_count < unlock_period)
                        retry_count = sat_count(int'(retry_count) + dt);
                    else
                    begin
                        retry_count = '0;
                        c.unlock    = 1'b1;
                    end
                end
            end

            // stick mapping
            if (f.lost)
                t = FAILSAFE_THR;
            else
            begin
                held_mode = position(f.aux1) + 2'd1;
                if (armed)
                begin
                    dr = apply_deadzone(int'(f.roll) - MID_VALUE, int'(dz_rp));
                    dp = apply_deadzone(int'(f.pitch) - MID_VALUE, int'(dz_rp));
                    dy = apply_deadzone(int'(f.yaw) - MID_VALUE, int'(dz_yaw));
                    r = saturate(dr * ANGLE_FULL_SCALE / ANGLE_DIV,
                                 -ANGLE_FULL_SCALE, ANGLE_FULL_SCALE);
                    p = saturate(-(dp * ANGLE_FULL_SCALE / ANGLE_DIV),
                                 -ANGLE_FULL_SCALE, ANGLE_FULL_SCALE);
                    y = saturate(-(dy * MAX_YAW / YAW_DIV), -MAX_YAW, MAX_YAW);
                    t = saturate(int'(f.thr) - LOW_VALUE, 0, THR_SPAN);
                end
            end

            c.roll     = r[12:0];
            c.pitch    = p[12:0];
            c.thr      = t[9:0];
            c.yaw      = y[8:0];
            c.mode     = held_mode;
            c.failsafe = f.lost;
            c.armed    = armed;
            c.radar    = radar;
            return c;
        endfunction

        function void note_frame(rc_frame_t f);
            pending_cmds.push_back(predict_commands(f));
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100)
                $display("error at %0t: %s", $realtime, msg);
        endtask

        task check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
            if (got !== want)
                report($sformatf("result %0d: %s is %0d, expected %0d",
                                 results_seen, name, got, want));
        endtask

        task check_cmds(cmd_set_t got);
            cmd_set_t want;
            results_seen++;
            if (pending_cmds.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                return;
            end
            want = pending_cmds.pop_front();
            check_field("roll_cmd", got.roll, want.roll);
            check_field("pitch_cmd", got.pitch, want.pitch);
            check_field("throttle_cmd", got.thr, want.thr);
            check_field("yaw_rate_cmd", got.yaw, want.yaw);
            check_field("flight_mode", got.mode, want.mode);
            check_field("failsafe_active", got.failsafe, want.failsafe);
            check_field("motors_armed", got.armed, want.armed);
            check_field("unlock_request", got.unlock, want.unlock);
            check_field("switch_positions", got.switches, want.switches);
            check_field("radar_power", got.radar, want.radar);
        endtask
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_write_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [11:0]               roll_channel;
    logic [11:0]               pitch_channel;
    logic [11:0]               throttle_channel;
    logic [11:0]               yaw_channel;
    logic [11:0]               aux1_channel;
    logic [11:0]               aux2_channel;
    logic [11:0]               aux3_channel;
    logic [11:0]               aux4_channel;
    logic [11:0]               aux5_channel;
    logic [11:0]               aux6_channel;
    logic                      link_lost;
    logic [7:0]                tick_ms;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [12:0]        roll_cmd;
    logic signed [12:0]        pitch_cmd;
    logic [9:0]                throttle_cmd;
    logic signed [8:0]         yaw_rate_cmd;
    logic [1:0]                flight_mode;
    logic                      failsafe_active;
    logic                      motors_armed;
    logic                      unlock_request;
    logic [11:0]               switch_positions;
    logic                      radar_power;

    cmd_scoreboard sb;
    cmd_set_t      dut_cmds;
    logic          calm;
    logic          long_hold_req;
    int            frames_sent;

    rc_stick_arming_and_command_mapper_core dut (.*);

    assign dut_cmds = {roll_cmd, pitch_cmd, throttle_cmd, yaw_rate_cmd, flight_mode,
                       failsafe_active, motors_armed, unlock_request, switch_positions,
                       radar_power};

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // frame builders
    function automatic logic [11:0] any_channel();
        return 12'($urandom_range(0, 4095));
    endfunction

    function automatic logic [11:0] stick_value();
        return ($urandom_range(0, 9) < 7) ? 12'($urandom_range(1000, 2000)) : any_channel();
    endfunction

    function automatic logic [11:0] below(logic [11:0] lim);
        return (lim == 12'd0) ? 12'd0 : 12'($urandom_range(0, int'(lim) - 1));
    endfunction

    function automatic logic [11:0] above(logic [11:0] lim);
        return (lim == 12'hFFF) ? 12'hFFF : 12'($urandom_range(int'(lim) + 1, 4095));
    endfunction

    function automatic rc_frame_t level(logic [11:0] v, logic lost, int tick);
        rc_frame_t f;
        f = {{10{v}}, lost, 8'(tick)};
        return f;
    endfunction

    function automatic rc_frame_t sticks(int roll, int pitch, int thr, int yaw, int tick);
        rc_frame_t f;
        f       = level(12'd1500, 1'b0, tick);
        f.roll  = 12'(roll);
        f.pitch = 12'(pitch);
        f.thr   = 12'(thr);
        f.yaw   = 12'(yaw);
        return f;
    endfunction

    function automatic rc_frame_t noise_frame();
        rc_frame_t f;
        f = {any_channel(), any_channel(), any_channel(), any_channel(), any_channel(),
             any_channel(), any_channel(), any_channel(), any_channel(), any_channel(),
             1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))};
        return f;
    endfunction

    function automatic rc_frame_t fly_frame();
        rc_frame_t f;
        f       = noise_frame();
        f.roll  = stick_value();
        f.pitch = stick_value();
        f.thr   = stick_value();
        f.yaw   = stick_value();
        f.lost  = 1'b0;
        return f;
    endfunction

    function automatic rc_frame_t arm_frame();
        rc_frame_t f;
        f       = fly_frame();
        f.thr   = below(sb.gesture_lo);
        f.yaw   = above(sb.gesture_hi);
        f.roll  = below(sb.gesture_lo);
        f.pitch = below(sb.gesture_lo);
        return f;
    endfunction

    function automatic rc_frame_t disarm_frame();
        rc_frame_t f;
        f       = fly_frame();
        f.thr   = below(sb.gesture_lo);
        f.yaw   = below(sb.gesture_lo);
        f.roll  = above(sb.gesture_hi);
        f.pitch = below(sb.gesture_lo);
        return f;
    endfunction

    task automatic drive_payload(input rc_frame_t f);
        roll_channel     = f.roll;
        pitch_channel    = f.pitch;
        throttle_channel = f.thr;
        yaw_channel      = f.yaw;
        aux1_channel     = f.aux1;
        aux2_channel     = f.aux2;
        aux3_channel     = f.aux3;
        aux4_channel     = f.aux4;
        aux5_channel     = f.aux5;
        aux6_channel     = f.aux6;
        link_lost        = f.lost;
        tick_ms          = f.tick;
    endtask

    // offer one item, possibly after an idle burst, and note it once accepted
    task automatic send_frame(input rc_frame_t f);
        int gap;
        gap = 0;
        if (!calm && ((frames_sent / 40) % 4 != 0) && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 15);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        drive_payload(f);
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_frame(f);
        frames_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = 16'(value);
        @(negedge clk);
        cfg_write_en = 1'b0;
        sb.set_reg(idx, cfg_data);
    endtask

    task automatic program_config(input int s_low, input int s_high, input int hold,
                                  input int retry, input int dz_rp, input int dz_yaw,
                                  input int sw_low, input int sw_high);
        write_reg(REG_GESTURE_LO, s_low);
        write_reg(REG_GESTURE_HI, s_high);
        write_reg(REG_ARM_HOLD_TIME, hold);
        write_reg(REG_UNLOCK_RETRY, retry);
        write_reg(REG_DEADZONE_RP, dz_rp);
        write_reg(REG_DEADZONE_YAW, dz_yaw);
        write_reg(REG_SW_LO, sw_low);
        write_reg(REG_SW_HI, sw_high);
    endtask

    // stop offering and wait for every expected command set
    task automatic drain_results();
        int waited;
        @(negedge clk);
        in_valid = 1'b0;
        waited   = 0;
        while (sb.pending_cmds.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending_cmds.size() != 0)
        begin
            sb.report($sformatf("%0d results never arrived", sb.pending_cmds.size()));
            sb.pending_cmds.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    // flight sessions: hold the arm gesture, fly, then drop out; plus some noise
    task automatic run_sessions(input int count);
        int sent, tries, legs, pick;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                send_frame(noise_frame());
                sent++;
            end
            else
            begin
                tries = 0;
                while (!sb.armed && tries < 40 && sent < count)
                begin
                    // now and then the gesture is broken mid-hold
                    if ($urandom_range(0, 19) == 0)
                        send_frame(fly_frame());
                    else
                        send_frame(arm_frame());
                    tries++;
                    sent++;
                end
                legs = $urandom_range(4, 40);
                while (legs > 0 && sent < count)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 4)
                        send_frame(noise_frame() | {120'd0, 1'b1, 8'd0});
                    else if (pick < 7)
                        send_frame(disarm_frame());
                    else
                        send_frame(fly_frame());
                    legs--;
                    sent++;
                end
            end
        end
    endtask

    // result side: accept results, idle in bursts, and one long hold-off on request
    initial
    begin
        int cyc;
        out_ready = 1'b0;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (long_hold_req)
            begin
                out_ready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
                out_ready     = 1'b1;
            end
            else if (!calm && ((cyc / 300) % 3 != 0) && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                out_ready = 1'b1;
            end
            else
                out_ready = 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_cmds(dut_cmds);
    end

    // stimulus
    initial
    begin
        rc_frame_t f;
        rst_n         = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = REG_GESTURE_LO;
        cfg_data      = '0;
        in_valid      = 1'b0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        frames_sent   = 0;
        drive_payload('0);
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed frames under reset configuration
        send_frame(level(12'd0, 1'b0, 0));
        send_frame(level(12'hFFF, 1'b0, 255));
        send_frame(level(12'hFFF, 1'b1, 255));
        send_frame(level(12'd0, 1'b1, 0));
        repeat (3) send_frame(sticks(0, 0, 0, 4095, 255));
        send_frame(sticks(1500, 1500, 1000, 1500, 50));
        send_frame(sticks(4095, 0, 4095, 4095, 60));
        send_frame(sticks(0, 4095, 2000, 0, 1));
        // deadzone edges on both sides
        send_frame(sticks(1540, 1460, 1999, 1580, 1));
        send_frame(sticks(1541, 1459, 1001, 1581, 1));
        send_frame(sticks(1459, 1541, 1500, 1419, 0));
        // signal loss while armed, then arm again and disarm by gesture
        f      = sticks(1500, 1500, 1500, 1500, 10);
        f.lost = 1'b1;
        send_frame(f);
        repeat (3) send_frame(sticks(0, 0, 0, 4095, 255));
        send_frame(sticks(4095, 0, 0, 0, 5));
        // switch thresholds
        f      = level(12'd1500, 1'b0, 1);
        f.aux1 = 12'd1199;
        f.aux2 = 12'd1200;
        f.aux3 = 12'd1699;
        f.aux4 = 12'd1700;
        f.aux5 = 12'd4095;
        f.aux6 = 12'd0;
        send_frame(f);
        f.aux5 = 12'd1200;
        send_frame(f);
        f.aux5 = 12'd0;
        send_frame(f);
        drain_results();

        // wide gesture windows, inverted switch limits, instant arming, unlock every frame
        program_config(4095, 0, 0, 0, 500, 500, 4095, 0);
        send_frame(sticks(0, 0, 0, 4094, 0));
        send_frame(sticks(0, 4095, 2000, 4095, 3));
        send_frame(sticks(2000, 1000, 1500, 1200, 0));
        send_frame(sticks(5, 0, 0, 0, 7));
        run_sessions(200);
        drain_results();

        // gestures impossible, largest hold time and retry period, no deadzone
        program_config(0, 4095, 65535, 65535, 0, 0, 0, 4095);
        run_sessions(150);
        drain_results();

        // random settings; one phase with a long receiver hold-off, the last one calm
        for (int ph = 0; ph < 4; ph++)
        begin
            program_config($urandom_range(900, 1300), $urandom_range(1700, 2100),
                           $urandom_range(0, 1500), $urandom_range(0, 600),
                           $urandom_range(0, 500), $urandom_range(0, 500),
                           $urandom_range(0, 4095), $urandom_range(0, 4095));
            if (ph == 1)
                long_hold_req = 1'b1;
            if (ph == 3)
                calm = 1'b1;
            run_sessions(PHASE_ITEMS);
            drain_results();
        end

        if (sb.errors == 0)
            $display("** rc_stick_arming_and_command_mapper_core: PASSED **");
        else
            $display("** rc_stick_arming_and_command_mapper_core: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("** rc_stick_arming_and_command_mapper_core: FAILED **");
        $finish;
    end

endmodule
